/* hdl/ssnd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnd_pkg
// Shared widths, command and status codes, and cell interface types for the
// sorted set nearest-distance block.
// ----------------------------------------------------------------------------
package ssnd_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	// Shift controls broadcast to every cell
	typedef struct packed {
		logic ins;
		logic ers;
	} cell_ctl_t;

	// Per-cell compare results against the incoming key
	typedef struct packed {
		logic lt;   // valid and value below key
		logic gt;   // empty or value above key
		logic eq;   // valid and value equal to key
	} cell_flags_t;

endpackage

/* hdl/ssnd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnd_cell
// One slot of the sorted chain: holds a value and a valid bit, compares it to
// the key and takes a neighbor's contents when the chain shifts.
// ----------------------------------------------------------------------------
module ssnd_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [ssnd_pkg::KEY_W-1:0]   key,
	input  ssnd_pkg::cell_ctl_t                 ctl,
	input  logic                                left_gt,
	input  logic                                left_valid,
	input  logic signed [ssnd_pkg::KEY_W-1:0]   left_value,
	input  logic                                right_valid,
	input  logic signed [ssnd_pkg::KEY_W-1:0]   right_value,
	output logic                                valid,
	output logic signed [ssnd_pkg::KEY_W-1:0]   value,
	output ssnd_pkg::cell_flags_t               flags
);
	import ssnd_pkg::*;

	logic                    valid_q;
	logic signed [KEY_W-1:0] value_q;
	logic                    valid_d;
	logic signed [KEY_W-1:0] value_d;

	assign valid    = valid_q;
	assign value    = value_q;
	assign flags.lt = valid_q && (value_q < key);
	assign flags.gt = !valid_q || (value_q > key);
	assign flags.eq = valid_q && (value_q == key);

	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		if (ctl.ins) begin
			// cells past the insertion point take the left neighbor
			if (left_gt) begin
				valid_d = left_valid;
				value_d = left_value;
			end else if (flags.gt) begin
				valid_d = 1'b1;
				value_d = key;
			end
		end else if (ctl.ers) begin
			// close the gap from the matching cell onward
			if (!flags.lt) begin
				valid_d = right_valid;
				value_d = right_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			value_q <= '0;
		end else begin
			valid_q <= valid_d;
			value_q <= value_d;
		end
	end

endmodule

/* hdl/sorted_set_nearest_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_nearest_distance
// Bounded set of distinct signed values kept sorted in a chain of cells,
// with insert, erase and nearest-distance query.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, s1 and the output register. The cell chain
// updates at the accept edge and the neighbor distance is computed in the
// following stage. One item is taken per cycle while the output is not stalled;
// a stalled output holds s1, which raises in_stall.
// Reset: asynchronous, clears every cell, the element count and all valids;
// the block can take items as soon as reset is released.
module sorted_set_nearest_distance (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ssnd_pkg::CMD_W-1:0]           command,
	input  logic signed [ssnd_pkg::KEY_W-1:0]    key_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ssnd_pkg::KEY_W-1:0]           distance,
	output logic [ssnd_pkg::STATUS_W-1:0]        status,
	output logic [ssnd_pkg::COUNT_W-1:0]         element_count
);
	import ssnd_pkg::*;

	localparam int LAST = CAPACITY - 1;

	cell_ctl_t               ctl;
	logic                    cell_valid [CAPACITY];
	logic signed [KEY_W-1:0] cell_value [CAPACITY];
	cell_flags_t             cell_flags [CAPACITY];

	logic                    accept;
	logic                    adv;
	logic                    any_eq;
	logic                    full;
	logic [COUNT_W-1:0]      count_q;
	logic [COUNT_W-1:0]      count_d;
	logic [STATUS_W-1:0]     status_d;
	logic                    pred_ok;
	logic                    succ_ok;
	logic [KEY_W-1:0]        pred_val;
	logic [KEY_W-1:0]        succ_val;

	logic                    valid_s1;
	logic signed [KEY_W-1:0] key_s1;
	logic signed [KEY_W-1:0] pred_s1;
	logic signed [KEY_W-1:0] succ_s1;
	logic                    pred_ok_s1;
	logic                    succ_ok_s1;
	logic                    query_s1;
	logic [STATUS_W-1:0]     status_s1;
	logic [COUNT_W-1:0]      count_s1;

	logic [KEY_W:0]          dpred;
	logic [KEY_W:0]          dsucc;
	logic [KEY_W-1:0]        dist_d;

	logic                    out_valid_q;
	logic [KEY_W-1:0]        distance_q;
	logic [STATUS_W-1:0]     status_q;
	logic [COUNT_W-1:0]      count_out_q;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	// cells stay packed at the low end, so the last cell tells full
	assign full = cell_valid[LAST];

	always_comb begin
		any_eq = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			any_eq = any_eq | cell_flags[i].eq;
		end
	end

	assign ctl.ins = accept && (command == CMD_INSERT) && !any_eq && !full;
	assign ctl.ers = accept && (command == CMD_ERASE) && any_eq;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic                    lgt;
			logic                    lvalid;
			logic signed [KEY_W-1:0] lvalue;
			logic                    rvalid;
			logic signed [KEY_W-1:0] rvalue;
			if (g == 0) begin : g_head
				assign lgt    = 1'b0;
				assign lvalid = 1'b0;
				assign lvalue = '0;
			end else begin : g_body
				assign lgt    = cell_flags[g-1].gt;
				assign lvalid = cell_valid[g-1];
				assign lvalue = cell_value[g-1];
			end
			if (g == LAST) begin : g_tail
				assign rvalid = 1'b0;
				assign rvalue = '0;
			end else begin : g_inner
				assign rvalid = cell_valid[g+1];
				assign rvalue = cell_value[g+1];
			end
			ssnd_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.key         (key_value),
				.ctl         (ctl),
				.left_gt     (lgt),
				.left_valid  (lvalid),
				.left_value  (lvalue),
				.right_valid (rvalid),
				.right_value (rvalue),
				.valid       (cell_valid[g]),
				.value       (cell_value[g]),
				.flags       (cell_flags[g])
			);
		end
	endgenerate

	// Pick the largest element below the key and the smallest at or above it
	always_comb begin
		pred_val = '0;
		succ_val = '0;
		succ_ok  = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_flags[i].lt && (i == LAST || !cell_flags[(i == LAST) ? i : i + 1].lt))
				pred_val = pred_val | cell_value[i];
			if (cell_valid[i] && !cell_flags[i].lt &&
			    (i == 0 || cell_flags[(i == 0) ? i : i - 1].lt)) begin
				succ_val = succ_val | cell_value[i];
				succ_ok  = 1'b1;
			end
		end
	end
	assign pred_ok = cell_flags[0].lt;

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		case (command)
			CMD_QUERY: begin
				if (count_q == '0)
					status_d = ST_EMPTY;
			end
			CMD_INSERT: begin
				if (any_eq)
					status_d = ST_DUP;
				else if (full)
					status_d = ST_FULL;
				else
					count_d = count_q + COUNT_W'(1);
			end
			CMD_ERASE: begin
				if (!any_eq)
					status_d = ST_NOT_FOUND;
				else
					count_d = count_q - COUNT_W'(1);
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1     <= key_value;
			pred_s1    <= pred_val;
			succ_s1    <= succ_val;
			pred_ok_s1 <= pred_ok;
			succ_ok_s1 <= succ_ok;
			query_s1   <= (command == CMD_QUERY) && (count_q != '0);
			status_s1  <= status_d;
			count_s1   <= count_d;
		end
	end

	// Exact differences; both are non-negative and fit in KEY_W bits
	assign dpred = {key_s1[KEY_W-1], key_s1} - {pred_s1[KEY_W-1], pred_s1};
	assign dsucc = {succ_s1[KEY_W-1], succ_s1} - {key_s1[KEY_W-1], key_s1};

	always_comb begin
		dist_d = '0;
		if (query_s1) begin
			if (pred_ok_s1 && succ_ok_s1)
				dist_d = (dpred[KEY_W-1:0] < dsucc[KEY_W-1:0]) ?
				         dpred[KEY_W-1:0] : dsucc[KEY_W-1:0];
			else if (pred_ok_s1)
				dist_d = dpred[KEY_W-1:0];
			else
				dist_d = dsucc[KEY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			distance_q  <= dist_d;
			status_q    <= status_s1;
			count_out_q <= count_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign distance      = distance_q;
	assign status        = status_q;
	assign element_count = count_out_q;

endmodule

/* hdl/ssnd_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnd_check
// Port-level checks on the result channel of the nearest-distance set.
// ----------------------------------------------------------------------------
module ssnd_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [ssnd_pkg::KEY_W-1:0]           distance,
	input  logic [ssnd_pkg::STATUS_W-1:0]        status,
	input  logic [ssnd_pkg::COUNT_W-1:0]         element_count
);
	import ssnd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance) &&
		$stable(status) && $stable(element_count))
		else $error("result item changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> element_count <= COUNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> element_count == '0 && distance == '0)
		else $error("empty status with nonzero count or distance");

	a_err_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUP || status == ST_NOT_FOUND || status == ST_FULL)
		|-> distance == '0)
		else $error("failed item carries a distance");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> element_count == COUNT_W'(CAPACITY))
		else $error("full status below capacity");

endmodule

bind sorted_set_nearest_distance ssnd_check u_ssnd_check (.*);

/* bench/tb_sorted_set_nearest_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_nearest_distance
// Drives insert, erase, query and spare-code items into the sorted set and
// checks every result against a behavioral set kept in the bench. A directed
// opening hits the signed extremes, the empty and full cases and duplicates;
// random bursts follow, including fill-to-full and drain-to-empty sequences,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_set_nearest_distance;
	import ssnd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam int TOTAL_ITEMS  = 1400;
	localparam int DRAIN_AT     = 700;   // sender waits for an empty pipe here
	localparam int HOLD_AT      = 400;   // results seen before the long hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_END     = 1150;  // no idling past this many items
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 20;
	localparam int REPORT_LIMIT = 10;

	typedef enum int {
		KEYS_NARROW,
		KEYS_WIDE,
		KEYS_EDGE
	} key_range_t;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [KEY_W-1:0] key;
		logic                    drain_first;
	} set_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]    nearest;
		logic [STATUS_W-1:0] stat;
		logic [COUNT_W-1:0]  count;
	} set_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        command = CMD_QUERY;
	logic signed [KEY_W-1:0] key_value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [KEY_W-1:0]        distance;
	logic [STATUS_W-1:0]     status;
	logic [COUNT_W-1:0]      element_count;

	sorted_set_nearest_distance u_top (.*);

	always #5 clk = ~clk;

	// Behavioral copy of the set
	logic signed [KEY_W-1:0] slot_key [CAPACITY];
	logic                    slot_used [CAPACITY];
	int                      member_count;

	set_item_t   pending_items [$];
	set_result_t expected_results [$];
	logic signed [KEY_W-1:0] planned_keys [$];  // set contents as the generator sees it

	int   items_accepted = 0;
	int   send_gap = 0;
	int   results_seen = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	int   fail_count = 0;
	int   quiet_cycles = 0;
	logic idle_ok;

	assign idle_ok = (items_accepted < IDLE_END) && ((items_accepted % 300) < 220);

	function automatic set_result_t apply_set_item(input logic [CMD_W-1:0] cmd,
			input logic signed [KEY_W-1:0] key);
		set_result_t r;
		int          i;
		int          hit;
		int          free_slot;
		longint      best;
		longint      d;
		r = '0;
		hit = -1;
		free_slot = -1;
		best = -1;
		for (i = 0; i < CAPACITY; i++) begin
			if (slot_used[i] && slot_key[i] == key && hit < 0)
				hit = i;
			if (!slot_used[i] && free_slot < 0)
				free_slot = i;
			if (slot_used[i]) begin
				d = longint'(slot_key[i]) - longint'(key);
				if (d < 0)
					d = -d;
				if (best < 0 || d < best)
					best = d;
			end
		end
		case (cmd)
			CMD_QUERY: begin
				if (member_count == 0)
					r.stat = ST_EMPTY;
				else
					r.nearest = best[KEY_W-1:0];
			end
			CMD_INSERT: begin
				if (hit >= 0)
					r.stat = ST_DUP;
				else if (free_slot < 0)
					r.stat = ST_FULL;
				else begin
					slot_used[free_slot] = 1'b1;
					slot_key[free_slot] = key;
					member_count++;
				end
			end
			CMD_ERASE: begin
				if (hit < 0)
					r.stat = ST_NOT_FOUND;
				else begin
					slot_used[hit] = 1'b0;
					slot_key[hit] = '0;
					member_count--;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(member_count);
		return r;
	endfunction

	function automatic int planned_index(input logic signed [KEY_W-1:0] key);
		int i;
		for (i = 0; i < planned_keys.size(); i++)
			if (planned_keys[i] == key)
				return i;
		return -1;
	endfunction

	task automatic plan_item(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key);
		int        idx;
		set_item_t item;
		idx = planned_index(key);
		if (cmd == CMD_INSERT && idx < 0 && planned_keys.size() < CAPACITY)
			planned_keys.push_back(key);
		if (cmd == CMD_ERASE && idx >= 0)
			planned_keys.delete(idx);
		item.cmd = cmd;
		item.key = key;
		item.drain_first = (pending_items.size() == DRAIN_AT);
		pending_items.push_back(item);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key(input key_range_t kind);
		logic [KEY_W-1:0] r;
		r = $urandom_range(0, 7);
		if (planned_keys.size() != 0 && $urandom_range(0, 9) < 4)
			return planned_keys[$urandom_range(0, planned_keys.size() - 1)];
		case (kind)
			KEYS_NARROW: return KEY_W'($urandom_range(0, 40)) - KEY_W'(20);
			KEYS_EDGE: begin
				case ($urandom_range(0, 2))
					0: return 32'h8000_0000 + r;
					1: return 32'h7FFF_FFFF - r;
					default: return r - KEY_W'(4);
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic plan_burst(input key_range_t kind);
		int n;
		int k;
		int op;
		n = $urandom_range(8, 40);
		for (k = 0; k < n; k++) begin
			op = $urandom_range(0, 99);
			if (op < 40)
				plan_item(CMD_INSERT, pick_key(kind));
			else if (op < 68)
				plan_item(CMD_ERASE, pick_key(kind));
			else if (op < 95)
				plan_item(CMD_QUERY, pick_key(kind));
			else
				plan_item(CMD_SPARE, $urandom);
		end
	endtask

	// Fill the table, push on it while full and query it, then erase everything
	task automatic plan_fill_and_drain();
		int k;
		while (planned_keys.size() < CAPACITY)
			plan_item(CMD_INSERT, $urandom);
		for (k = 0; k < 3; k++)
			plan_item(CMD_INSERT, $urandom);
		plan_item(CMD_INSERT, planned_keys[$urandom_range(0, CAPACITY - 1)]);
		for (k = 0; k < 6; k++)
			plan_item(CMD_QUERY, pick_key(k % 2 ? KEYS_EDGE : KEYS_WIDE));
		plan_item(CMD_ERASE, planned_keys[$urandom_range(0, CAPACITY - 1)]);
		plan_item(CMD_INSERT, $urandom);
		while (planned_keys.size() > 0) begin
			plan_item(CMD_ERASE, planned_keys[$urandom_range(0, planned_keys.size() - 1)]);
			if ($urandom_range(0, 7) == 0)
				plan_item(CMD_QUERY, $urandom);
		end
		plan_item(CMD_QUERY, $urandom);
		plan_item(CMD_ERASE, $urandom);
	endtask

	// Sender
	always @(posedge clk or negedge arst_n) begin
		set_item_t next_item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_QUERY;
			key_value <= '0;
			items_accepted <= 0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_set_item(command, key_value));
				items_accepted <= items_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_items[0].drain_first && expected_results.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					command <= next_item.cmd;
					key_value <= next_item.key;
					if (idle_ok && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 15);
				end
			end
		end
	end

	// Receiver and checker
	always @(posedge clk or negedge arst_n) begin
		set_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid === 1'b1 && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected result %0d: distance %0d status %0d count %0d",
							results_seen, distance, status, element_count);
				end else begin
					want = expected_results.pop_front();
					if (distance !== want.nearest || status !== want.stat ||
							element_count !== want.count) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"result %0d: expected distance %0d status %0d count %0d,",
								" got distance %0d status %0d count %0d"}, results_seen,
								want.nearest, want.stat, want.count,
								distance, status, element_count);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				// Long hold-off: let the block back up into its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_ok && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int k;
		int fills;
		for (i = 0; i < CAPACITY; i++) begin
			slot_key[i] = '0;
			slot_used[i] = 1'b0;
		end
		member_count = 0;

		// Empty set, spare code and the signed extremes
		plan_item(CMD_QUERY, 32'sd0);
		plan_item(CMD_ERASE, 32'sd5);
		plan_item(CMD_SPARE, 32'hFFFF_FFFF);
		plan_item(CMD_INSERT, 32'h7FFF_FFFF);
		plan_item(CMD_QUERY, 32'h8000_0000);
		plan_item(CMD_INSERT, 32'h7FFF_FFFF);
		plan_item(CMD_INSERT, 32'h8000_0000);
		plan_item(CMD_QUERY, 32'sd0);
		plan_item(CMD_QUERY, -32'sd1);
		plan_item(CMD_QUERY, 32'h8000_0000);
		plan_item(CMD_QUERY, 32'h7FFF_FFFF);
		plan_item(CMD_INSERT, 32'sd0);
		plan_item(CMD_QUERY, 32'h5555_5555);
		plan_item(CMD_QUERY, 32'hAAAA_AAAA);
		plan_item(CMD_ERASE, 32'h7FFF_FFFF);
		plan_item(CMD_ERASE, 32'h7FFF_FFFF);
		plan_item(CMD_QUERY, 32'h7FFF_FFFF);
		plan_item(CMD_SPARE, 32'h1234_5678);
		plan_item(CMD_ERASE, 32'sd0);
		plan_item(CMD_ERASE, 32'h8000_0000);
		plan_item(CMD_QUERY, 32'sd3);
		plan_item(CMD_INSERT, -32'sd1);
		plan_item(CMD_INSERT, 32'sd1);
		plan_item(CMD_QUERY, 32'sd0);

		fills = 0;
		plan_fill_and_drain();
		while (pending_items.size() < TOTAL_ITEMS) begin
			k = $urandom_range(0, 9);
			if (k == 0 && fills < 2) begin
				fills++;
				plan_fill_and_drain();
			end else if (k < 4)
				plan_burst(KEYS_NARROW);
			else if (k < 7)
				plan_burst(KEYS_EDGE);
			else
				plan_burst(KEYS_WIDE);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_items.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
